@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the request parser and responder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/hrp_pkg.sv @@
// Shared types, constants and helper functions for the HCI request parser.
// No dependencies; imported by every module of the block.
package hrp_pkg;

  localparam logic [7:0]  START_BYTE      = 8'hA5;
  localparam logic [15:0] CRC_POLY        = 16'h8408;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [7:0]  LINK_MODE_RESET = 8'd10;

  localparam int MAX_PAYLOAD = 96;
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] EP_HOST  = 2'd1;
  localparam logic [1:0] EP_RADIO = 2'd2;

  // request ids
  localparam logic [7:0] MSG_PING   = 8'h01;
  localparam logic [7:0] MSG_SETCFG = 8'h03;
  localparam logic [7:0] MSG_GETCFG = 8'h05;
  localparam logic [7:0] MSG_INFO   = 8'h0F;
  localparam logic [7:0] MSG_SEND1  = 8'h01;
  localparam logic [7:0] MSG_SEND4  = 8'h04;

  // response ids
  localparam logic [7:0] RSP_PING   = 8'h02;
  localparam logic [7:0] RSP_SETCFG = 8'h04;
  localparam logic [7:0] RSP_GETCFG = 8'h06;
  localparam logic [7:0] RSP_INFO   = 8'h10;
  localparam logic [7:0] RSP_SEND1  = 8'h02;
  localparam logic [7:0] RSP_SEND4  = 8'h05;

  localparam logic [7:0] INFO_B0   = 8'h33;
  localparam logic [7:0] INFO_B2   = 8'h15;
  localparam logic [7:0] INFO_B3   = 8'h16;
  localparam logic [7:0] GETCFG_B0 = 8'h12;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CTRL,
    PH_MSGID,
    PH_LEN,
    PH_PAYLOAD
  } ph_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HDR,
    BK_DATA,
    BK_TRAIL
  } bk_state_t;

  typedef enum logic [2:0] {
    K_PING,
    K_INFO,
    K_GETCFG,
    K_SEND1,
    K_SEND4,
    K_SCHDR,
    K_SCBYTE
  } cmd_kind_t;

  // one queued response job
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] arg;    // length, echoed byte or link mode
    logic       last;   // set-config: append the CRC trailer
    logic       radio;  // radio state after the request word
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    logic [7:0]  v;
    c = c_in;
    v = b;
    for (int k = 0; k < 8; k++) begin
      if ((v[0] ^ c[0]) == 1'b1) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      v = v >> 1;
    end
    return c;
  endfunction

  function automatic logic [7:0] rsp_ctrl(input cmd_kind_t kind);
    logic [7:0] r;
    r = 8'h80 | {6'd0, EP_HOST};
    if (kind == K_SEND1 || kind == K_SEND4) begin
      r = 8'h80 | {6'd0, EP_RADIO};
    end
    return r;
  endfunction

  function automatic logic [7:0] rsp_id(input cmd_kind_t kind);
    logic [7:0] r;
    case (kind)
      K_PING:   r = RSP_PING;
      K_INFO:   r = RSP_INFO;
      K_GETCFG: r = RSP_GETCFG;
      K_SEND1:  r = RSP_SEND1;
      K_SEND4:  r = RSP_SEND4;
      K_SCHDR:  r = RSP_SETCFG;
      default:  r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rsp_len(input cmd_kind_t kind, input logic [7:0] arg);
    logic [7:0] r;
    case (kind)
      K_INFO, K_GETCFG: r = 8'd8;
      K_SCHDR:          r = arg;
      default:          r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] data_byte(input cmd_kind_t kind, input logic [2:0] idx,
                                           input logic [7:0] arg, input logic [31:0] uid);
    logic [7:0] r;
    r = arg;
    if (kind == K_INFO) begin
      case (idx)
        3'd0:    r = INFO_B0;
        3'd1:    r = 8'h00;
        3'd2:    r = INFO_B2;
        3'd3:    r = INFO_B3;
        3'd4:    r = uid[7:0];
        3'd5:    r = uid[15:8];
        3'd6:    r = uid[23:16];
        default: r = uid[31:24];
      endcase
    end else if (kind == K_GETCFG) begin
      case (idx)
        3'd0:    r = GETCFG_B0;
        3'd1:    r = arg;
        3'd2:    r = uid[7:0];
        3'd3:    r = uid[15:8];
        3'd4:    r = uid[23:16];
        3'd5:    r = uid[31:24];
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

endpackage

@@ hdl/hrp_parser.sv @@
// Front end: hunts for frames in the host byte stream and turns each
// request into response jobs for the command queue. Depends on hrp_pkg.
module hrp_parser import hrp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  ph_t              phase, phase_next;
  logic [1:0]       endpoint_id, endpoint_id_next;
  logic [7:0]       message_id, message_id_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [LEN_W-1:0] payload_index, payload_index_next;
  logic [7:0]       link_mode, link_mode_next;
  logic             radio_on, radio_on_next;

  logic             acc;
  logic             set_cfg;
  logic             len_bad;
  logic             len_zero;
  logic [LEN_W:0]   idx_inc;
  logic             pay_last;
  logic             fin;
  logic             fin_known;
  cmd_kind_t        fin_kind;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign set_cfg  = (endpoint_id == EP_HOST) && (message_id == MSG_SETCFG);
  assign len_bad  = in_byte > 8'(MAX_PAYLOAD);
  assign len_zero = in_byte == 8'd0;
  assign idx_inc  = {1'b0, payload_index} + (LEN_W + 1)'(1);
  assign pay_last = idx_inc >= {1'b0, frame_length};
  assign fin      = ((phase == PH_LEN) && !len_bad && len_zero) ||
                    ((phase == PH_PAYLOAD) && pay_last);

  // response job for a request that completes with a fixed answer
  always_comb begin
    fin_known = 1'b0;
    fin_kind  = K_PING;
    if (endpoint_id == EP_HOST) begin
      case (message_id)
        MSG_PING:   begin fin_known = 1'b1; fin_kind = K_PING;   end
        MSG_INFO:   begin fin_known = 1'b1; fin_kind = K_INFO;   end
        MSG_GETCFG: begin fin_known = 1'b1; fin_kind = K_GETCFG; end
        default:    fin_known = 1'b0;
      endcase
    end else if (endpoint_id == EP_RADIO) begin
      case (message_id)
        MSG_SEND1: begin fin_known = 1'b1; fin_kind = K_SEND1; end
        MSG_SEND4: begin fin_known = 1'b1; fin_kind = K_SEND4; end
        default:   fin_known = 1'b0;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_next = phase;
    if (acc) begin
      case (phase)
        PH_HUNT: begin
          if (in_byte == START_BYTE) phase_next = PH_CTRL;
        end
        PH_CTRL: begin
          // control byte is legal only as endpoint 1 or 2 with no flag bits
          if (in_byte inside {{6'd0, EP_HOST}, {6'd0, EP_RADIO}}) phase_next = PH_MSGID;
          else phase_next = PH_HUNT;
        end
        PH_MSGID: phase_next = PH_LEN;
        PH_LEN: begin
          if (len_bad || len_zero) phase_next = PH_HUNT;
          else phase_next = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (pay_last) phase_next = PH_HUNT;
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  // outputs and data registers
  always_comb begin
    endpoint_id_next   = endpoint_id;
    message_id_next    = message_id;
    frame_length_next  = frame_length;
    payload_index_next = payload_index;
    link_mode_next     = link_mode;
    radio_on_next      = radio_on;
    q_push             = 1'b0;
    q_cmd.kind         = K_SCBYTE;
    q_cmd.arg          = in_byte;
    q_cmd.last         = 1'b0;
    q_cmd.radio        = radio_on;
    if (acc) begin
      case (phase)
        PH_CTRL:  endpoint_id_next = in_byte[1:0];
        PH_MSGID: message_id_next = in_byte;
        PH_LEN: begin
          if (!len_bad) begin
            frame_length_next  = in_byte[LEN_W-1:0];
            payload_index_next = '0;
            if (set_cfg) begin
              q_push     = 1'b1;
              q_cmd.kind = K_SCHDR;
              q_cmd.last = len_zero;
            end
          end
        end
        PH_PAYLOAD: begin
          payload_index_next = idx_inc[LEN_W-1:0];
          if (set_cfg) begin
            q_push     = 1'b1;
            q_cmd.kind = K_SCBYTE;
            q_cmd.last = pay_last;
            if (payload_index == LEN_W'(2)) link_mode_next = in_byte;
          end
        end
        default: ;
      endcase
      if (fin) begin
        if (set_cfg) begin
          radio_on_next = 1'b1;
          q_cmd.radio   = 1'b1;
        end else if (fin_known) begin
          q_push      = 1'b1;
          q_cmd.kind  = fin_kind;
          q_cmd.arg   = link_mode;
          q_cmd.last  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      endpoint_id   <= '0;
      message_id    <= '0;
      frame_length  <= '0;
      payload_index <= '0;
      link_mode     <= LINK_MODE_RESET;
      radio_on      <= 1'b0;
    end else begin
      phase         <= phase_next;
      endpoint_id   <= endpoint_id_next;
      message_id    <= message_id_next;
      frame_length  <= frame_length_next;
      payload_index <= payload_index_next;
      link_mode     <= link_mode_next;
      radio_on      <= radio_on_next;
    end
  end

endmodule

@@ hdl/hrp_cmd_fifo.sv @@
// Short job queue between the request parser and the responder.
// Depends on hrp_pkg for the job type and depth.
`include "assert_macros.svh"
module hrp_cmd_fifo import hrp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic empty
);

  cmd_t             slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = count == CNT_W'(FIFO_DEPTH);
  assign empty  = count == '0;
  assign rd_cmd = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  `ASSERT_IMP(a_no_overflow, clk, rst, push, !full || pop)
  `ASSERT_IMP(a_no_underflow, clk, rst, pop, !empty)
  `ASSERT_NXT(a_count_up, clk, rst, push && !pop, count == $past(count) + CNT_W'(1))

endmodule

@@ hdl/hrp_responder.sv @@
// Back end: expands queued jobs into response frame bytes with CRC-16
// and holds each byte in the output register. Depends on hrp_pkg.
`include "assert_macros.svh"
module hrp_responder import hrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] unit_id,
  input  logic        q_empty,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        frame_end,
  output logic        radio_enabled
);

  bk_state_t   state, state_next;
  logic [2:0]  pos, pos_next;
  cmd_t        cmd;
  logic [15:0] crc;

  logic        advance;
  logic        has_data;
  logic        has_trail;
  logic [7:0]  byte_val;
  logic        byte_crc;
  logic        byte_end;

  assign advance   = (state != BK_IDLE) && (!out_valid || out_ready);
  assign q_pop     = (state == BK_IDLE) && !q_empty;
  assign has_data  = (cmd.kind == K_INFO) || (cmd.kind == K_GETCFG);
  // set-config jobs close the frame only on their final word
  assign has_trail = !((cmd.kind == K_SCHDR) || (cmd.kind == K_SCBYTE)) || cmd.last;

  // next state
  always_comb begin
    state_next = state;
    pos_next   = pos;
    case (state)
      BK_IDLE: begin
        if (q_pop) begin
          state_next = (q_cmd.kind == K_SCBYTE) ? BK_DATA : BK_HDR;
          pos_next   = '0;
        end
      end
      BK_HDR: begin
        if (advance) begin
          if (pos == 3'd3) begin
            pos_next = '0;
            if (has_data) state_next = BK_DATA;
            else if (has_trail) state_next = BK_TRAIL;
            else state_next = BK_IDLE;
          end else begin
            pos_next = pos + 3'd1;
          end
        end
      end
      BK_DATA: begin
        if (advance) begin
          if (cmd.kind == K_SCBYTE || pos == 3'd7) begin
            pos_next   = '0;
            state_next = has_trail ? BK_TRAIL : BK_IDLE;
          end else begin
            pos_next = pos + 3'd1;
          end
        end
      end
      BK_TRAIL: begin
        if (advance) begin
          if (pos == 3'd1) begin
            pos_next   = '0;
            state_next = BK_IDLE;
          end else begin
            pos_next = pos + 3'd1;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // byte selection
  always_comb begin
    byte_val = 8'h00;
    byte_crc = 1'b0;
    byte_end = 1'b0;
    case (state)
      BK_HDR: begin
        byte_crc = 1'b1;
        case (pos)
          3'd0: begin
            byte_val = START_BYTE;
            byte_crc = 1'b0;
          end
          3'd1:    byte_val = rsp_ctrl(cmd.kind);
          3'd2:    byte_val = rsp_id(cmd.kind);
          default: byte_val = rsp_len(cmd.kind, cmd.arg);
        endcase
      end
      BK_DATA: begin
        byte_crc = 1'b1;
        byte_val = data_byte(cmd.kind, pos, cmd.arg, unit_id);
      end
      BK_TRAIL: begin
        if (pos == 3'd0) begin
          byte_val = ~crc[7:0];
        end else begin
          byte_val = ~crc[15:8];
          byte_end = 1'b1;
        end
      end
      default: byte_val = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      if (advance) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd <= q_cmd;
    if (advance) begin
      out_byte      <= byte_val;
      frame_end     <= byte_end;
      radio_enabled <= cmd.radio;
      if (state == BK_HDR && pos == 3'd0) crc <= CRC_INIT;
      else if (byte_crc) crc <= crc_byte(crc, byte_val);
    end
  end

  `ASSERT_NXT(a_load_starts, clk, rst, q_pop, state != BK_IDLE)
  `ASSERT_IMP(a_data_kind, clk, rst, state == BK_DATA,
              cmd.kind == K_INFO || cmd.kind == K_GETCFG || cmd.kind == K_SCBYTE)
  `ASSERT_NXT(a_trail_pair, clk, rst, state == BK_TRAIL && pos == 3'd0 && advance,
              state == BK_TRAIL && pos == 3'd1)

endmodule

@@ hdl/hci_request_parser_responder.sv @@
// Serial HCI request parser and responder: host bytes in, response frame
// bytes out (0xA5, 0x80|ep, id, len, payload, inverted CRC-16 low byte first).
// A host byte is accepted every clock while the four-entry job queue has room;
// the responder sends one frame byte per clock while out_ready allows it, and
// returns to its idle state to load each job from the queue; an echoed
// set-config byte carries the CRC trailer only on the last byte.
// Depends on hrp_pkg, hrp_parser, hrp_cmd_fifo and hrp_responder.
module hci_request_parser_responder import hrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        frame_end,
  output logic        radio_enabled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0] unit_id;
  logic        q_full, q_empty, q_push, q_pop;
  cmd_t        q_wr, q_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_id <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unit_id <= cfg_data;
    end
  end

  hrp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_wr)
  );

  hrp_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (q_wr),
    .full   (q_full),
    .pop    (q_pop),
    .rd_cmd (q_rd),
    .empty  (q_empty)
  );

  hrp_responder u_resp (
    .clk           (clk),
    .rst           (rst),
    .unit_id       (unit_id),
    .q_empty       (q_empty),
    .q_cmd         (q_rd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .frame_end     (frame_end),
    .radio_enabled (radio_enabled)
  );

endmodule

@@ tb/hrp_checker.sv @@
// Checker for the HCI request parser: watches the host, response and unit-id
// channels, predicts every response word and compares field by field.
// Depends on hrp_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 100ps
module hrp_checker import hrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        frame_end,
  input  logic        radio_enabled,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        drain_check,
  output int          n_errors,
  output int          n_pending
);

  localparam logic [7:0] CTRL_FLAGS = 8'hF8;
  localparam logic [7:0] RSP_DIR    = 8'h80;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       radio;
  } rsp_word_t;

  rsp_word_t rsp_q[$];   // expected response words, oldest first
  rsp_word_t step_q[$];  // words caused by the current host word
  rsp_word_t want;

  ph_t              phase;
  logic [1:0]       ep;
  logic [7:0]       msg;
  logic [LEN_W-1:0] flen;
  logic [LEN_W-1:0] pidx;
  logic [7:0]       link_mode;
  logic             radio;
  logic [15:0]      crc;
  logic [31:0]      uid;
  logic             drain_seen;
  int               n_words;

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("%0t: mismatch at response word %0d: %s", $realtime, n_words, what);
  endtask

  task automatic put_word(input logic [7:0] b, input logic last);
    rsp_word_t w;
    w.data  = b;
    w.last  = last;
    w.radio = 1'b0;
    step_q.push_back(w);
  endtask

  // reflected CRC-16, one byte, LSB first
  task automatic put_crc_word(input logic [7:0] b);
    logic [15:0] c;
    logic [7:0]  v;
    int          k;
    c = crc;
    v = b;
    for (k = 0; k < 8; k++) begin
      if (c[0] ^ v[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      v = v >> 1;
    end
    crc = c;
    put_word(b, 1'b0);
  endtask

  task automatic open_frame(input logic [1:0] rep, input logic [7:0] id, input logic [7:0] len);
    crc = CRC_INIT;
    put_word(START_BYTE, 1'b0);
    put_crc_word(RSP_DIR | {6'd0, rep});
    put_crc_word(id);
    put_crc_word(len);
  endtask

  task automatic close_frame();
    logic [15:0] c;
    c = ~crc;
    put_word(c[7:0], 1'b0);
    put_word(c[15:8], 1'b1);
  endtask

  task automatic send_fixed(input logic [1:0] rep, input logic [7:0] id,
                            input logic [7:0][7:0] d, input int len);
    int i;
    open_frame(rep, id, len[7:0]);
    for (i = 0; i < len; i++) begin
      put_crc_word(d[i]);
    end
    close_frame();
  endtask

  function automatic logic is_setcfg();
    return ep == EP_HOST && msg == MSG_SETCFG;
  endfunction

  task automatic complete_request();
    logic [7:0][7:0] d;
    d = '0;
    phase = PH_HUNT;
    if (ep == EP_HOST) begin
      case (msg)
        MSG_PING: send_fixed(EP_HOST, RSP_PING, d, 0);
        MSG_INFO: begin
          d = {uid, INFO_B3, INFO_B2, 8'h00, INFO_B0};
          send_fixed(EP_HOST, RSP_INFO, d, 8);
        end
        MSG_GETCFG: begin
          d = {16'h0000, uid, link_mode, GETCFG_B0};
          send_fixed(EP_HOST, RSP_GETCFG, d, 8);
        end
        MSG_SETCFG: begin
          radio = 1'b1;
          close_frame();
        end
        default: ;
      endcase
    end else if (ep == EP_RADIO) begin
      if (msg == MSG_SEND1) begin
        send_fixed(EP_RADIO, RSP_SEND1, d, 0);
      end else if (msg == MSG_SEND4) begin
        send_fixed(EP_RADIO, RSP_SEND4, d, 0);
      end
    end
  endtask

  task automatic parse_host_byte(input logic [7:0] b);
    step_q.delete();
    case (phase)
      PH_HUNT: begin
        if (b == START_BYTE) phase = PH_CTRL;
      end
      PH_CTRL: begin
        if ((b & CTRL_FLAGS) != 8'h00 ||
            (b[3:0] != {2'b00, EP_HOST} && b[3:0] != {2'b00, EP_RADIO})) begin
          phase = PH_HUNT;
        end else begin
          ep = b[1:0];
          phase = PH_MSGID;
        end
      end
      PH_MSGID: begin
        msg = b;
        phase = PH_LEN;
      end
      PH_LEN: begin
        if (b > MAX_PAYLOAD) begin
          phase = PH_HUNT;
        end else begin
          flen = b[LEN_W-1:0];
          pidx = '0;
          if (is_setcfg()) open_frame(EP_HOST, RSP_SETCFG, b);
          if (b == 8'd0) begin
            complete_request();
          end else begin
            phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (is_setcfg()) begin
          put_crc_word(b);
          if (pidx == LEN_W'(2)) link_mode = b;
        end
        pidx = pidx + LEN_W'(1);
        if (pidx >= flen) complete_request();
      end
      default: phase = PH_HUNT;
    endcase
    // radio flag reflects the state after the whole host word
    foreach (step_q[i]) begin
      step_q[i].radio = radio;
      rsp_q.push_back(step_q[i]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase      = PH_HUNT;
      ep         = '0;
      msg        = '0;
      flen       = '0;
      pidx       = '0;
      link_mode  = LINK_MODE_RESET;
      radio      = 1'b0;
      crc        = CRC_INIT;
      uid        = '0;
      drain_seen = 1'b0;
      n_words    = 0;
      n_errors   = 0;
      rsp_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) uid = cfg_data;
      if (in_valid && in_ready) parse_host_byte(in_byte);
      if (out_valid && out_ready) begin
        if (rsp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_byte));
        end else begin
          want = rsp_q.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.data));
          if (frame_end !== want.last)
            report_mismatch($sformatf("frame_end %b, want %b", frame_end, want.last));
          if (radio_enabled !== want.radio)
            report_mismatch($sformatf("radio_enabled %b, want %b", radio_enabled, want.radio));
        end
        n_words++;
      end
      if (drain_check && !drain_seen) begin
        drain_seen = 1'b1;
        if (rsp_q.size() != 0)
          report_mismatch($sformatf("%0d expected words never sent", rsp_q.size()));
      end
    end
    n_pending = rsp_q.size();
  end

endmodule

@@ tb/tb_hci_request_parser_responder.sv @@
// Testbench top for hci_request_parser_responder: clock, reset, host requests,
// unit-id writes and response back-pressure; checking is done in hrp_checker.
// Depends on hrp_pkg, hrp_checker and the block's RTL.
`timescale 1ns / 100ps
module tb_hci_request_parser_responder;
  import hrp_pkg::*;

  localparam int         STALL_LIMIT   = 2000;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         PHASE_BYTES   = 24;
  localparam logic [7:0] HOST_CTRL     = {6'd0, EP_HOST};
  localparam logic [7:0] RADIO_CTRL    = {6'd0, EP_RADIO};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        frame_end;
  logic        radio_enabled;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = 32'h0;
  logic        drain_check = 1'b0;
  logic        idle_on = 1'b1;
  int          n_errors;
  int          n_pending;
  int          n_sent = 0;
  int          stall_cnt = 0;

  always #4 clk = ~clk;

  hci_request_parser_responder DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .frame_end     (frame_end),
    .radio_enabled (radio_enabled),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  hrp_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .frame_end     (frame_end),
    .radio_enabled (radio_enabled),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .drain_check   (drain_check),
    .n_errors      (n_errors),
    .n_pending     (n_pending)
  );

  // watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // response side back-pressure
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic send_frame(input logic [7:0] ctrl, input logic [7:0] id,
                            input logic [7:0] len, input int n_pay);
    send_byte(START_BYTE);
    send_byte(ctrl);
    send_byte(id);
    send_byte(len);
    repeat (n_pay) send_byte($urandom_range(0, 255));
  endtask

  task automatic send_bad_ctrl();
    logic [7:0] b;
    b = $urandom_range(0, 255);
    if (b[7:3] == 5'd0 && (b[2:0] == 3'd1 || b[2:0] == 3'd2)) b[7] = 1'b1;
    send_byte(START_BYTE);
    send_byte(b);
  endtask

  // sender holds off until every expected word is out and the block settles
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (n_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_uid(input logic [31:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_len();
    return $urandom_range(0, 6);
  endfunction

  task automatic run_random(input int budget);
    int start;
    int pick;
    int len;
    start = n_sent;
    while (n_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      len  = pick_len();
      if (pick < 12) begin
        send_frame(HOST_CTRL, MSG_PING, len, len);
      end else if (pick < 24) begin
        send_frame(HOST_CTRL, MSG_INFO, len, len);
      end else if (pick < 36) begin
        send_frame(HOST_CTRL, MSG_GETCFG, len, len);
      end else if (pick < 54) begin
        send_frame(HOST_CTRL, MSG_SETCFG, len, len);
      end else if (pick < 62) begin
        send_frame(RADIO_CTRL, MSG_SEND1, len, len);
      end else if (pick < 70) begin
        send_frame(RADIO_CTRL, MSG_SEND4, len, len);
      end else if (pick < 78) begin
        send_frame($urandom_range(0, 1) ? HOST_CTRL : RADIO_CTRL,
                   $urandom_range(0, 255), len, len);
      end else if (pick < 84) begin
        send_byte($urandom_range(0, 255));
      end else if (pick < 90) begin
        send_bad_ctrl();
      end else if (pick < 95) begin
        send_frame(HOST_CTRL, $urandom_range(0, 255), $urandom_range(MAX_PAYLOAD + 1, 255), 0);
      end else begin
        // set config cut short; following words land in its payload
        len = $urandom_range(3, 8);
        send_frame(HOST_CTRL, MSG_SETCFG, len, $urandom_range(0, len - 1));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_uid(32'hFFFF_FFFF);

    // directed: hunting noise, each host request, a radio send-4, each rejection
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(HOST_CTRL, MSG_PING, 8'd0, 0);
    send_frame(HOST_CTRL, MSG_INFO, 8'd0, 0);
    send_frame(HOST_CTRL, MSG_SETCFG, 8'd3, 3);
    send_frame(HOST_CTRL, MSG_GETCFG, 8'd0, 0);
    send_frame(RADIO_CTRL, MSG_SEND4, 8'd1, 1);
    send_bad_ctrl();
    send_frame(HOST_CTRL, MSG_PING, MAX_PAYLOAD + 1, 0);
    send_frame(HOST_CTRL, 8'h22, 8'd0, 0);

    write_uid(32'h0000_0000);
    run_random(PHASE_BYTES / 2);
    wait_drained();
    run_random(PHASE_BYTES / 2);

    write_uid($urandom);
    run_random(PHASE_BYTES);

    write_uid($urandom);
    idle_on <= 1'b0;
    run_random(PHASE_BYTES);
    // longest legal length, left open: header and two echoes only
    send_frame(HOST_CTRL, MSG_SETCFG, 8'(MAX_PAYLOAD), 2);

    wait_drained();
    drain_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
